### sv/szl_pkg.sv
package szl_pkg;

	// field widths
	localparam int ANG_W  = 16;
	localparam int TURB_W = 16;
	localparam int LUM_W  = 24;
	localparam int CHR_W  = 16;

	localparam logic [TURB_W-1:0] TURB_RESET = 16'd8192;

	// angle constants
	localparam logic [15:0]        PI_Q14      = 16'd51472;
	localparam logic signed [27:0] PI_Q24      = 28'sd52707179;
	localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;

	// turbidity terms, Q.24
	localparam logic [23:0] FOUR_NINTHS_Q24 = 24'd7456540;
	localparam logic [17:0] INV120_Q24      = 18'd139810;
	localparam logic [26:0] YA_Q24          = 27'd67868872;
	localparam logic [26:0] YB_Q24          = 27'd83399541;
	localparam logic [21:0] YC_Q24          = 22'd3615490;
	localparam logic [25:0] YD_Q24          = 26'd40587441;

	// cordic and divider depths
	localparam int CORDIC_N = 24;
	localparam int DIV_N    = 35;

	// tangent saturation, +2048 in Q.24
	localparam logic signed [36:0] TAN_LIMIT = 37'sd34359738368;

	localparam logic signed [27:0] ATAN_Q24 [8] = '{
		28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
		28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069
	};

	// [x or y][row T^2, T, 1][theta^3, theta^2, theta, 1], Q.24
	localparam logic signed [24:0] CHROMA_COEF [2][3][4] = '{
		'{ '{  25'sd27682,   -25'sd62915,   25'sd35064,        25'sd0 },
		   '{ -25'sd487043,   25'sd1069883, -25'sd537206,   25'sd66102 },
		   '{  25'sd1961760, -25'sd3556099,  25'sd1015357, 25'sd4342950 } },
		'{ '{  25'sd46137,   -25'sd102341,  25'sd53184,        25'sd0 },
		   '{ -25'sd706992,   25'sd1504916, -25'sd696758,   25'sd86570 },
		   '{  25'sd2574632, -25'sd4488912,  25'sd1119040, 25'sd4477503 } }
	};

	// values that ride along the cordic and divider rows
	typedef struct packed {
		logic signed [19:0] slope;
		logic signed [26:0] base;
		logic signed [15:0] chroma_x;
		logic signed [15:0] chroma_y;
	} side_t;

	typedef struct packed {
		logic signed [30:0] x;
		logic signed [30:0] y;
		logic signed [27:0] r;
		side_t              side;
	} cordic_t;

	typedef struct packed {
		logic [29:0] ay;
		logic [29:0] dv;
		logic [29:0] rem;
		logic [34:0] q;
		logic        sat;
		logic        neg;
		side_t       side;
	} div_t;

	function automatic logic signed [27:0] cordic_step(input int i);
		logic signed [27:0] s;
		if (i < 8) begin
			s = ATAN_Q24[i];
		end else begin
			s = 28'sd1 <<< (24 - i);
		end
		return s;
	endfunction

	// one polynomial row in theta, rounded to Q.24
	function automatic logic signed [30:0] row_q24(input int w, input int k,
			input logic [19:0] th3, input logic [17:0] th2, input logic [15:0] th);
		logic signed [47:0] acc;
		acc = 48'(CHROMA_COEF[w][k][0]) * $signed({28'd0, th3})
			+ 48'(CHROMA_COEF[w][k][1]) * $signed({30'd0, th2})
			+ 48'(CHROMA_COEF[w][k][2]) * $signed({32'd0, th})
			+ 48'(CHROMA_COEF[w][k][3]) * 48'sd16384
			+ 48'sd8192;
		return 31'(acc >>> 14);
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
		logic signed [15:0] r;
		if (v > 36'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -36'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = 16'(v);
		end
		return r;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
		logic signed [23:0] r;
		if (v > 34'sd8388607) begin
			r = 24'sh7fffff;
		end else if (v < -34'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = 24'(v);
		end
		return r;
	endfunction

endpackage

### sv/sky_zenith_luminance.sv
// path: front stages, cordic row, divider seed, divider row, product, output
// throughput: one angle per cycle; the 24 cordic cells and 35 divider cells
// each finish one step a cycle, and the whole row stalls while a result is held
// reset: all valid flags clear at once, turbidity returns to 2.0 (8192)
module sky_zenith_luminance import szl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,   // turbidity
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // sun_zenith_angle
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata      // zenith_luminance, zenith_chroma_x, zenith_chroma_y
);

	logic en;
	logic [TURB_W-1:0] turb_q;

	// the row moves whenever the output register is free or being taken
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// turbidity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turb_q <= TURB_RESET;
		end else if (cfg_wen) begin
			turb_q <= cfg_wdata;
		end
	end

	// front stages
	cordic_t cc [CORDIC_N+1];
	logic    cv [CORDIC_N+1];

	szl_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_tvalid),
		.theta   (s_tdata),
		.turb    (turb_q),
		.out_vld (cv[0]),
		.out_d   (cc[0])
	);

	// cordic row
	for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
		szl_cordic_cell #(.IDX(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_vld  (cv[i]),
			.in_d    (cc[i]),
			.out_vld (cv[i+1]),
			.out_d   (cc[i+1])
		);
	end

	// pole test and divider seed
	cordic_t     cend;
	logic [29:0] ay_c;
	logic        sat_c;
	div_t        dd [DIV_N+1];
	logic        dvl [DIV_N+1];
	div_t        dseed_q;
	logic        dseed_vld_q;

	assign cend = cc[CORDIC_N];

	always_comb begin
		ay_c  = cend.y[30] ? 30'(-cend.y) : cend.y[29:0];
		sat_c = cend.x[30] || (cend.x == '0)
			|| ({12'd0, ay_c[29:11]} >= $unsigned(cend.x));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dseed_q.ay   <= ay_c;
			dseed_q.dv   <= cend.x[29:0];
			dseed_q.rem  <= {11'd0, ay_c[29:11]};
			dseed_q.q    <= '0;
			dseed_q.sat  <= sat_c;
			dseed_q.neg  <= cend.y[30];
			dseed_q.side <= cend.side;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dseed_vld_q <= 1'b0;
		end else if (en) begin
			dseed_vld_q <= cv[CORDIC_N];
		end
	end

	assign dd[0]  = dseed_q;
	assign dvl[0] = dseed_vld_q;

	// divider row, quotient msb first
	for (genvar j = 0; j < DIV_N; j++) begin : g_div
		szl_div_cell #(.BIT(DIV_N - 1 - j)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_vld  (dvl[j]),
			.in_d    (dd[j]),
			.out_vld (dvl[j+1]),
			.out_d   (dd[j+1])
		);
	end

	// signed tangent and luminance product
	div_t dend;
	logic signed [36:0] tn_c;
	logic signed [57:0] prod_s1;
	logic signed [15:0] cx_s1, cy_s1;
	logic vld_s1;

	assign dend = dd[DIV_N];

	always_comb begin
		if (dend.sat) begin
			tn_c = dend.neg ? -TAN_LIMIT : TAN_LIMIT;
		end else if (dend.neg) begin
			tn_c = -$signed({2'b00, dend.q});
		end else begin
			tn_c = $signed({2'b00, dend.q});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 58'(dend.side.slope) * 58'(tn_c)
				+ (58'(dend.side.base) <<< 12) + 58'sd8388608;
			cx_s1   <= dend.side.chroma_x;
			cy_s1   <= dend.side.chroma_y;
		end
	end

	// output register
	logic signed [23:0] lum_s2;
	logic signed [15:0] cx_s2, cy_s2;
	logic vld_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			lum_s2 <= sat24(34'(prod_s1 >>> 24));
			cx_s2  <= cx_s1;
			cy_s2  <= cy_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= dvl[DIV_N];
			vld_s2 <= vld_s1;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {cy_s2, cx_s2, lum_s2};

endmodule

### sv/szl_front.sv
module szl_front import szl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic [ANG_W-1:0]    theta,
	input  logic [TURB_W-1:0]   turb,
	output logic                out_vld,
	output cordic_t             out_d
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	// stage 1: theta^2, chi factor, turbidity products
	logic [32:0] th_sq;
	logic [33:0] t_inv;
	logic [42:0] t_ya;
	logic [37:0] t_yc;
	logic [15:0] th_s1, t_s1;
	logic [17:0] th2_s1;
	logic signed [24:0] k24_s1;
	logic signed [17:0] a14_s1;
	logic [30:0] tya_s1;
	logic [25:0] tyc_s1;

	assign th_sq = 33'(theta) * 33'(theta) + 33'd8192;
	assign t_inv = 34'(turb) * 34'(INV120_Q24) + 34'd2048;
	assign t_ya  = 43'(turb) * 43'(YA_Q24) + 43'd2048;
	assign t_yc  = 38'(turb) * 38'(YC_Q24) + 38'd2048;

	always_ff @(posedge clk) begin
		if (en) begin
			th_s1  <= theta;
			t_s1   <= turb;
			th2_s1 <= th_sq[31:14];
			k24_s1 <= $signed(25'(FOUR_NINTHS_Q24) - 25'(t_inv[33:12]));
			a14_s1 <= $signed(18'(PI_Q14) - 18'({theta, 1'b0}));
			tya_s1 <= t_ya[42:12];
			tyc_s1 <= t_yc[37:12];
		end
	end

	// stage 2: theta^3, chi, slope and base of the luminance line
	logic [33:0] th_cu;
	logic signed [42:0] chi_p;
	logic signed [32:0] sl;
	logic [15:0] th_s2, t_s2;
	logic [17:0] th2_s2;
	logic [19:0] th3_s2;
	logic signed [27:0] chi_s2;
	logic signed [19:0] slope_s2;
	logic signed [26:0] base_s2;

	assign th_cu = 34'(th2_s1) * 34'(th_s1) + 34'd8192;
	assign chi_p = 43'(k24_s1) * 43'(a14_s1) + 43'sd8192;
	assign sl    = $signed({2'b00, tya_s1}) - $signed(33'(YB_Q24)) + 33'sd2048;

	always_ff @(posedge clk) begin
		if (en) begin
			th_s2    <= th_s1;
			t_s2     <= t_s1;
			th2_s2   <= th2_s1;
			th3_s2   <= th_cu[33:14];
			chi_s2   <= 28'(chi_p >>> 14);
			slope_s2 <= 20'(sl >>> 12);
			base_s2  <= $signed(27'(YD_Q24)) - $signed({1'b0, tyc_s1});
		end
	end

	// stage 3: polynomial rows, angle folded into the cordic range
	logic signed [30:0] row_c [2][3];
	logic signed [27:0] r_c;
	logic signed [30:0] row_s3 [2][3];
	logic signed [27:0] r_s3;
	logic [15:0] t_s3;
	logic signed [19:0] slope_s3;
	logic signed [26:0] base_s3;

	always_comb begin
		for (int w = 0; w < 2; w++) begin
			for (int k = 0; k < 3; k++) begin
				row_c[w][k] = row_q24(w, k, th3_s2, th2_s2, th_s2);
			end
		end
		if (chi_s2 > HALF_PI_Q24) begin
			r_c = chi_s2 - PI_Q24;
		end else if (chi_s2 < -HALF_PI_Q24) begin
			r_c = chi_s2 + PI_Q24;
		end else begin
			r_c = chi_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s3   <= row_c;
			r_s3     <= r_c;
			t_s3     <= t_s2;
			slope_s3 <= slope_s2;
			base_s3  <= base_s2;
		end
	end

	// stage 4: rows times turbidity
	logic signed [47:0] m0 [2];
	logic signed [47:0] m1 [2];
	logic signed [40:0] p0_s4 [2];
	logic signed [31:0] p1_s4 [2];
	logic signed [30:0] row2_s4 [2];
	logic [15:0] t_s4;
	logic signed [27:0] r_s4;
	logic signed [19:0] slope_s4;
	logic signed [26:0] base_s4;

	always_comb begin
		for (int w = 0; w < 2; w++) begin
			m0[w] = 48'(row_s3[w][0]) * $signed({32'd0, t_s3});
			m1[w] = 48'(row_s3[w][1]) * $signed({32'd0, t_s3}) + 48'sd2048;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int w = 0; w < 2; w++) begin
				p0_s4[w]   <= 41'(m0[w]);
				p1_s4[w]   <= 32'(m1[w] >>> 12);
				row2_s4[w] <= row_s3[w][2];
			end
			t_s4     <= t_s3;
			r_s4     <= r_s3;
			slope_s4 <= slope_s3;
			base_s4  <= base_s3;
		end
	end

	// stage 5: second turbidity factor on the T^2 row
	logic signed [57:0] m2 [2];
	logic signed [32:0] q0_s5 [2];
	logic signed [31:0] p1_s5 [2];
	logic signed [30:0] row2_s5 [2];
	logic signed [27:0] r_s5;
	logic signed [19:0] slope_s5;
	logic signed [26:0] base_s5;

	always_comb begin
		for (int w = 0; w < 2; w++) begin
			m2[w] = 58'(p0_s4[w]) * $signed({42'd0, t_s4}) + 58'sd8388608;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int w = 0; w < 2; w++) begin
				q0_s5[w]   <= 33'(m2[w] >>> 24);
				p1_s5[w]   <= p1_s4[w];
				row2_s5[w] <= row2_s4[w];
			end
			r_s5     <= r_s4;
			slope_s5 <= slope_s4;
			base_s5  <= base_s4;
		end
	end

	// stage 6: sum rows, round to Q.12, saturate; seed the cordic vector
	logic signed [35:0] csum [2];
	logic signed [15:0] chroma [2];

	always_comb begin
		for (int w = 0; w < 2; w++) begin
			csum[w]   = 36'(q0_s5[w]) + 36'(p1_s5[w]) + 36'(row2_s5[w]) + 36'sd2048;
			chroma[w] = sat16(csum[w] >>> 12);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d.x             <= 31'sd268435456;
			out_d.y             <= '0;
			out_d.r             <= r_s5;
			out_d.side.slope    <= slope_s5;
			out_d.side.base     <= base_s5;
			out_d.side.chroma_x <= chroma[0];
			out_d.side.chroma_y <= chroma[1];
		end
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	assign out_vld = vld_s6;

endmodule

### sv/szl_cordic_cell.sv
module szl_cordic_cell import szl_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_vld,
	input  cordic_t in_d,
	output logic    out_vld,
	output cordic_t out_d
);

	localparam logic signed [27:0] STEP = cordic_step(IDX);

	logic signed [30:0] dx, dy;
	cordic_t nxt;

	// one rotation toward zero residual angle
	always_comb begin
		dx  = in_d.y >>> IDX;
		dy  = in_d.x >>> IDX;
		nxt = in_d;
		if (in_d.r >= 0) begin
			nxt.x = in_d.x - dx;
			nxt.y = in_d.y + dy;
			nxt.r = in_d.r - STEP;
		end else begin
			nxt.x = in_d.x + dx;
			nxt.y = in_d.y - dy;
			nxt.r = in_d.r + STEP;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

endmodule

### sv/szl_div_cell.sv
module szl_div_cell import szl_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  div_t in_d,
	output logic out_vld,
	output div_t out_d
);

	logic        dbit;
	logic [30:0] tmp;
	logic        ge;
	div_t        nxt;

	// next dividend bit: |y| shifted up by 24
	if (BIT >= 24) begin : g_bit
		assign dbit = in_d.ay[BIT-24];
	end else begin : g_zero
		assign dbit = 1'b0;
	end

	// one restoring step, one quotient bit
	always_comb begin
		tmp     = {in_d.rem, dbit};
		ge      = tmp >= {1'b0, in_d.dv};
		nxt     = in_d;
		nxt.rem = ge ? 30'(tmp - {1'b0, in_d.dv}) : tmp[29:0];
		nxt.q   = {in_d.q[33:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

endmodule

### sv/szl_checker.sv
module szl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	// a held result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a held result keeps its data
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// input side stalls exactly when a result is held
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	// no result right after reset release
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result present after reset");

endmodule

bind sky_zenith_luminance szl_checker u_chk (.*);
